/* sv/ppz_pkg.sv */
package ppz_pkg;

	localparam int unsigned MaxPixelsDef = 4096;
	localparam logic [15:0] FarDepth = 16'sd16384;

	typedef enum logic [1:0] {
		REQ_PLOT  = 2'd0,
		REQ_CLEAR = 2'd1,
		REQ_READ  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		CFG_ROW_X  = 3'd0,
		CFG_ROW_Y  = 3'd1,
		CFG_ROW_Z  = 3'd2,
		CFG_ROW_W  = 3'd3,
		CFG_VIEW   = 3'd4,
		CFG_WIDTH  = 3'd5,
		CFG_HEIGHT = 3'd6,
		CFG_BACK   = 3'd7
	} cfg_idx_t;

	// front unit states
	typedef enum logic [2:0] {
		F_IDLE, F_MUL, F_SUM, F_DX, F_DY, F_DZ, F_IDX, F_OUT
	} fst_t;

	// back unit states
	typedef enum logic [2:0] {B_INIT, B_IDLE, B_RD, B_TEST, B_CLR, B_OUT} bst_t;

	// front to back queue entry
	typedef struct packed {
		req_t         kind;
		logic         pass;
		logic [15:0]  px;
		logic [15:0]  py;
		logic [15:0]  depth;
		logic [7:0]   glyph;
		logic [15:0]  index;
	} cmd_t;

endpackage

/* sv/ppz_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned operands.
module ppz_div import ppz_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        done,
	output logic [63:0] quo
);
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [64:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign quo = quo_q;
endmodule

/* sv/ppz_front.sv */
// Transform, divide and bounds check; one request in flight.
module ppz_front import ppz_pkg::*; #(
	parameter int unsigned MaxPixels = MaxPixelsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic signed [15:0] point_z,
	input  logic [7:0]  glyph,
	input  logic [11:0] pixel_index,
	input  logic [63:0] row_x,
	input  logic [63:0] row_y,
	input  logic [63:0] row_z,
	input  logic [63:0] row_w,
	input  logic [63:0] view,
	input  logic [8:0]  img_w,
	input  logic [8:0]  img_h,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);
	fst_t st_q, st_d;
	logic signed [15:0] x_q, y_q, z_q;
	logic [7:0]  g_q;
	logic [15:0] pi_q;
	req_t kind_q;
	logic [1:0] row_q;
	logic [1:0] term_q;
	logic signed [47:0] acc_q;
	logic signed [47:0] cx_q, cy_q, cz_q, cw_q;
	logic signed [31:0] prod;
	logic signed [15:0] coef, coord;
	logic [63:0] rsel;
	logic signed [63:0] num_q, den_q;
	logic neg_q;
	logic start_q;
	logic dv_done;
	logic [63:0] dv_quo;
	logic [63:0] unum, uden;
	logic bad_q;
	logic [15:0] px_q, py_q, dep_q;
	logic [31:0] idx_w;
	logic signed [63:0] sdq;

	always_comb begin
		unique case (row_q)
			2'd0: rsel = row_x;
			2'd1: rsel = row_y;
			2'd2: rsel = row_z;
			default: rsel = row_w;
		endcase
		unique case (term_q)
			2'd0: begin coef = rsel[15:0];  coord = x_q; end
			2'd1: begin coef = rsel[31:16]; coord = y_q; end
			2'd2: begin coef = rsel[47:32]; coord = z_q; end
			default: begin coef = rsel[63:48]; coord = 16'sd256; end
		endcase
	end
	assign prod = coef * coord;

	assign unum = num_q[63] ? 64'(-num_q) : 64'(num_q);
	assign uden = den_q[63] ? 64'(-den_q) : 64'(den_q);
	assign sdq  = (neg_q ? -$signed(dv_quo) : $signed(dv_quo));

	ppz_div u_div (
		.clk(clk), .arst_n(arst_n), .start(start_q),
		.num(unum), .den(uden), .done(dv_done), .quo(dv_quo)
	);

	assign idx_w = 32'(py_q) * 32'(img_w) + 32'(px_q);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			F_IDLE: if (in_valid) st_d = (req_type == REQ_PLOT) ? F_MUL : F_OUT;
			F_MUL:  if (row_q == 2'd3 && term_q == 2'd3) st_d = F_SUM;
			F_SUM:  st_d = (cw_q == 0) ? F_OUT : F_DX;
			F_DX:   if (dv_done) st_d = F_DY;
			F_DY:   if (dv_done) st_d = F_DZ;
			F_DZ:   if (dv_done) st_d = F_IDX;
			F_IDX:  st_d = F_OUT;
			F_OUT:  if (cmd_ready) st_d = F_IDLE;
			default: st_d = F_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (st_q == F_IDLE);
		cmd_valid = (st_q == F_OUT);
		cmd.kind  = kind_q;
		cmd.pass  = !bad_q;
		cmd.px    = px_q;
		cmd.py    = py_q;
		cmd.depth = dep_q;
		cmd.glyph = g_q;
		cmd.index = pi_q;
	end

	function automatic logic signed [63:0] axis_num(input logic signed [47:0] c,
			input logic signed [47:0] w, input logic [15:0] off, input logic [15:0] sz);
		logic signed [63:0] a;
		a = (64'(c) + 64'(w)) * $signed({48'd0, sz}) +
			2 * $signed({48'd0, off}) * 64'(w);
		return a;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
			start_q <= 1'b0;
		end else begin
			st_q <= st_d;
			start_q <= (st_q == F_SUM && cw_q != 0) ||
				(dv_done && (st_q == F_DX || st_q == F_DY));
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			F_IDLE: begin
				x_q <= point_x; y_q <= point_y; z_q <= point_z;
				g_q <= glyph; pi_q <= 16'(pixel_index);
				kind_q <= req_t'(req_type);
				row_q <= '0; term_q <= '0; acc_q <= '0; bad_q <= 1'b0;
				px_q <= '0; py_q <= '0; dep_q <= '0;
			end
			F_MUL: begin
				term_q <= term_q + 2'd1;
				if (term_q == 2'd3) begin
					row_q <= row_q + 2'd1;
					acc_q <= '0;
					unique case (row_q)
						2'd0: cx_q <= acc_q + 48'(prod);
						2'd1: cy_q <= acc_q + 48'(prod);
						2'd2: cz_q <= acc_q + 48'(prod);
						default: cw_q <= acc_q + 48'(prod);
					endcase
				end else begin
					acc_q <= acc_q + 48'(prod);
				end
			end
			F_SUM: begin
				bad_q <= (cw_q == 0);
				num_q <= axis_num(cx_q, cw_q, view[15:0], view[47:32]);
				den_q <= 64'(cw_q) <<< 1;
				neg_q <= 1'b0;
			end
			F_DX: if (dv_done) begin
				if ((num_q[63] != den_q[63]) && unum != 0 ||
					dv_quo >= 64'(img_w)) bad_q <= 1'b1;
				px_q <= dv_quo[15:0];
				num_q <= axis_num(cy_q, cw_q, view[31:16], view[63:48]);
			end
			F_DY: if (dv_done) begin
				if ((num_q[63] != den_q[63]) && unum != 0 ||
					dv_quo >= 64'(img_h)) bad_q <= 1'b1;
				py_q <= dv_quo[15:0];
				num_q <= 64'(cz_q) <<< 14;
				den_q <= 64'(cw_q);
				neg_q <= cz_q[47] ^ cw_q[47];
			end
			F_DZ: if (dv_done) begin
				if (sdq > 64'sd32767) dep_q <= 16'h7fff;
				else if (sdq < -64'sd32768) dep_q <= 16'h8000;
				else dep_q <= sdq[15:0];
			end
			F_IDX: begin
				if (idx_w >= 32'(MaxPixels)) bad_q <= 1'b1;
				pi_q <= idx_w[15:0];
			end
			default: ;
		endcase
	end
endmodule

/* sv/ppz_back.sv */
// Store access: clear sweep, read, depth test and write.
module ppz_back import ppz_pkg::*; #(
	parameter int unsigned MaxPixels = MaxPixelsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	input  logic [7:0]  back_glyph,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        written,
	output logic [7:0]  pixel_glyph,
	output logic signed [15:0] pixel_depth,
	output logic [11:0] out_index
);
	localparam int AW = $clog2(MaxPixels);

	bst_t st_q, st_d;
	logic [7:0]  gmem [MaxPixels];
	logic [15:0] dmem [MaxPixels];
	logic [AW:0] clr_q;
	logic [7:0]  fill_q;
	logic [AW-1:0] addr_q;
	logic [7:0]  rg_q;
	logic [15:0] rd_q;
	cmd_t c_q;
	logic inrange;
	logic hit;
	logic we;
	logic [7:0] wg;
	logic [15:0] wd;

	assign inrange = ({1'b0, c_q.index} < 17'(MaxPixels));
	assign hit = $signed(c_q.depth) < $signed(rd_q);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			B_INIT: if (clr_q[AW]) st_d = B_IDLE;
			B_IDLE: if (cmd_valid) begin
				unique case (cmd.kind)
					REQ_CLEAR: st_d = B_CLR;
					REQ_NONE:  st_d = B_OUT;
					REQ_PLOT:  st_d = cmd.pass ? B_RD : B_OUT;
					default:   st_d = B_RD;
				endcase
			end
			B_RD:   st_d = B_TEST;
			B_TEST: st_d = B_OUT;
			B_CLR:  if (clr_q[AW]) st_d = B_OUT;
			B_OUT:  if (out_ready) st_d = B_IDLE;
			default: st_d = B_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = (st_q == B_IDLE);
		out_valid = (st_q == B_OUT);
		we = 1'b0; wg = fill_q; wd = FarDepth;
		if (st_q == B_INIT || st_q == B_CLR) we = !clr_q[AW];
		else if (st_q == B_TEST && c_q.kind == REQ_PLOT && hit) begin
			we = 1'b1; wg = c_q.glyph; wd = c_q.depth;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_INIT;
			clr_q <= '0;
			fill_q <= 8'd32;
		end else begin
			st_q <= st_d;
			if (st_q == B_INIT || st_q == B_CLR) begin
				if (!clr_q[AW]) clr_q <= clr_q + 1'b1;
			end else if (st_d == B_CLR) begin
				clr_q <= '0;
				fill_q <= back_glyph;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			gmem[(st_q == B_TEST) ? addr_q : clr_q[AW-1:0]] <= wg;
			dmem[(st_q == B_TEST) ? addr_q : clr_q[AW-1:0]] <= wd;
		end
		rg_q <= gmem[addr_q];
		rd_q <= dmem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (st_q == B_IDLE && cmd_valid) begin
			c_q <= cmd;
			addr_q <= AW'(cmd.index);
		end
		unique case (st_q)
			B_IDLE: begin
				written <= 1'b0; pixel_glyph <= '0;
				pixel_depth <= '0; out_index <= '0;
			end
			B_TEST: begin
				out_index <= c_q.index[11:0];
				if (inrange) begin
					if (c_q.kind == REQ_PLOT && hit) begin
						written <= 1'b1; pixel_glyph <= c_q.glyph;
						pixel_depth <= c_q.depth;
					end else begin
						pixel_glyph <= rg_q; pixel_depth <= rd_q;
					end
				end
			end
			B_CLR: begin
				pixel_glyph <= fill_q; pixel_depth <= FarDepth;
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_no_out_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == B_INIT |-> !out_valid) else $error("output during init");
	a_write_only_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && written |-> c_q.kind == REQ_PLOT) else $error("bad written");
	a_clear_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && c_q.kind == REQ_CLEAR |-> pixel_depth == FarDepth)
		else $error("clear depth");
`endif
endmodule

/* sv/point_project_zbuffer_splat.sv */
// Plot, clear and read requests each return one result. In the front unit a
// plot takes 16 multiply steps, then, if w is nonzero, three 64-step serial
// divides (x, y, depth). Clear sweeps MaxPixels store entries, one per cycle;
// the same sweep runs after reset before the back takes its first command.
// A one-entry queue sits between the transform front and the store back.
module point_project_zbuffer_splat import ppz_pkg::*; #(
	parameter int unsigned MaxPixels = MaxPixelsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic signed [15:0] point_z,
	input  logic [7:0]  glyph,
	input  logic [11:0] pixel_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        written,
	output logic [7:0]  pixel_glyph,
	output logic signed [15:0] pixel_depth,
	output logic [11:0] out_index,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	logic [63:0] rx_q, ry_q, rz_q, rw_q, vp_q;
	logic [8:0]  iw_q, ih_q;
	logic [7:0]  bg_q;
	logic f_valid, f_ready, b_valid, b_ready;
	cmd_t f_cmd, q_cmd;
	logic qv_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_q <= '0; ry_q <= '0; rz_q <= '0; rw_q <= '0; vp_q <= '0;
			iw_q <= 9'd64; ih_q <= 9'd64; bg_q <= 8'd32;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ROW_X:  rx_q <= cfg_data;
				CFG_ROW_Y:  ry_q <= cfg_data;
				CFG_ROW_Z:  rz_q <= cfg_data;
				CFG_ROW_W:  rw_q <= cfg_data;
				CFG_VIEW:   vp_q <= cfg_data;
				CFG_WIDTH:  iw_q <= cfg_data[8:0];
				CFG_HEIGHT: ih_q <= cfg_data[8:0];
				default:    bg_q <= cfg_data[7:0];
			endcase
		end
	end

	ppz_front #(.MaxPixels(MaxPixels)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .point_x(point_x), .point_y(point_y),
		.point_z(point_z), .glyph(glyph), .pixel_index(pixel_index),
		.row_x(rx_q), .row_y(ry_q), .row_z(rz_q), .row_w(rw_q), .view(vp_q),
		.img_w(iw_q), .img_h(ih_q),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	assign f_ready = !qv_q;
	assign b_valid = qv_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) qv_q <= 1'b0;
		else if (f_valid && f_ready) qv_q <= 1'b1;
		else if (b_ready) qv_q <= 1'b0;
	end
	always_ff @(posedge clk) if (f_valid && f_ready) q_cmd <= f_cmd;

	ppz_back #(.MaxPixels(MaxPixels)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(b_valid), .cmd_ready(b_ready),
		.cmd(q_cmd), .back_glyph(bg_q), .out_valid(out_valid),
		.out_ready(out_ready), .written(written), .pixel_glyph(pixel_glyph),
		.pixel_depth(pixel_depth), .out_index(out_index)
	);
endmodule
